// File: sv/mrrs_pkg.sv
`timescale 1ns / 1ps

package mrrs_pkg;

   localparam int NUM_TASKS  = 64;
   localparam int NUM_LEVELS = 8;

   // index and count widths
   localparam int TW  = $clog2(NUM_TASKS);
   localparam int CW  = $clog2(NUM_TASKS + 1);
   localparam int LW  = $clog2(NUM_LEVELS);
   localparam int CLW = $clog2(NUM_LEVELS + 1);

   localparam int SLOT_W     = 2 + LW + 8;
   localparam int LIST_AW    = LW + TW;
   localparam int LIST_DEPTH = 2 ** LIST_AW;

   typedef enum logic [1:0] {
      FUNC_ALLOC = 2'd0,
      FUNC_RUN   = 2'd1,
      FUNC_SLEEP = 2'd2,
      FUNC_TICK  = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_FREE  = 2'd0,
      ST_ALLOC = 2'd1,
      ST_RUN   = 2'd2
   } sstate_type;

   typedef struct packed {
      sstate_type      st;
      logic [LW-1:0]   lv;
      logic [7:0]      sl;
   } slot_type;

   // datapath step codes
   typedef enum logic [4:0] {
      OP_NONE   = 5'd0,
      OP_LATCH  = 5'd1,
      OP_INIT0  = 5'd2,
      OP_INIT1  = 5'd3,
      OP_A_RD   = 5'd4,
      OP_A_CK   = 5'd5,
      OP_T_RD   = 5'd6,
      OP_T_CK   = 5'd7,
      OP_R_RD   = 5'd8,
      OP_R_CK   = 5'd9,
      OP_H_RD   = 5'd10,
      OP_H_WR   = 5'd11,
      OP_APPEND = 5'd12,
      OP_SDONE  = 5'd13,
      OP_P_RD   = 5'd14,
      OP_P_CK   = 5'd15,
      OP_ADV    = 5'd16,
      OP_L_RD   = 5'd17,
      OP_L_CK   = 5'd18
   } op_type;

   typedef struct packed {
      op_type op;
      logic   ph;
   } cmd_type;

   typedef struct packed {
      func_type func;
      logic     slot_free;
      logic     idx_last;
      logic     is_run;
      logic     need_rm;
      logic     rm_end;
      logic     found;
      logic     avail;
   } stat_type;

   // slot contents after reset
   function automatic slot_type slot_rst(input logic [TW-1:0] idx);
      slot_type s;
      s.st = ST_FREE;
      s.lv = '0;
      s.sl = 8'd0;
      if (idx == TW'(0)) begin
         s.st = ST_RUN;
         s.sl = 8'd2;
      end else if (idx == TW'(1)) begin
         s.st = ST_RUN;
         s.lv = LW'(NUM_LEVELS - 1);
         s.sl = 8'd1;
      end
      return s;
   endfunction

endpackage

// File: sv/mrrs_ram.sv
`timescale 1ns / 1ps

module mrrs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // one write port, registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: sv/mrrs_ctrl.sv
`timescale 1ns / 1ps

module mrrs_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [1:0]          req_func,
   input  logic [5:0]          req_task_id,
   input  mrrs_pkg::stat_type  stat,
   output mrrs_pkg::cmd_type   cmd,
   output logic                busy,
   output logic                rsp_valid
);

   typedef enum logic [18:0] {
      S_INIT0 = 19'h00001,
      S_INIT1 = 19'h00002,
      S_IDLE  = 19'h00004,
      S_A_RD  = 19'h00008,
      S_A_CK  = 19'h00010,
      S_T_RD  = 19'h00020,
      S_T_CK  = 19'h00040,
      S_R_RD  = 19'h00080,
      S_R_CK  = 19'h00100,
      S_H_RD  = 19'h00200,
      S_H_WR  = 19'h00400,
      S_APP   = 19'h00800,
      S_SDONE = 19'h01000,
      S_P_RD  = 19'h02000,
      S_P_CK  = 19'h04000,
      S_ADV   = 19'h08000,
      S_L_RD  = 19'h10000,
      S_L_CK  = 19'h20000,
      S_RESP  = 19'h40000
   } state_type;

   state_type state_ff, state_in;
   logic      ph_ff, ph_in;
   logic      is_run_f;

   assign is_run_f = (stat.func == mrrs_pkg::FUNC_RUN);

   // next state
   always_comb begin
      state_in = state_ff;
      ph_in    = ph_ff;
      cmd.op   = mrrs_pkg::OP_NONE;
      cmd.ph   = ph_ff;
      unique case (state_ff)
         S_INIT0: begin
            cmd.op   = mrrs_pkg::OP_INIT0;
            state_in = S_INIT1;
         end
         S_INIT1: begin
            cmd.op   = mrrs_pkg::OP_INIT1;
            state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               cmd.op = mrrs_pkg::OP_LATCH;
               ph_in  = 1'b1;
               case (mrrs_pkg::func_type'(req_func))
                  mrrs_pkg::FUNC_ALLOC: state_in = S_A_RD;
                  mrrs_pkg::FUNC_TICK: begin
                     state_in = S_P_RD;
                     ph_in    = 1'b0;
                  end
                  default: begin
                     if (int'(req_task_id) < mrrs_pkg::NUM_TASKS) begin
                        state_in = S_T_RD;
                     end else begin
                        state_in = S_P_RD;
                     end
                  end
               endcase
            end
         end
         S_A_RD: begin
            cmd.op   = mrrs_pkg::OP_A_RD;
            state_in = S_A_CK;
         end
         S_A_CK: begin
            cmd.op = mrrs_pkg::OP_A_CK;
            if (stat.slot_free || stat.idx_last) begin
               state_in = S_RESP;
            end else begin
               state_in = S_A_RD;
            end
         end
         S_T_RD: begin
            cmd.op   = mrrs_pkg::OP_T_RD;
            state_in = S_T_CK;
         end
         S_T_CK: begin
            cmd.op = mrrs_pkg::OP_T_CK;
            if (is_run_f) begin
               state_in = stat.need_rm ? S_R_RD : S_APP;
            end else begin
               state_in = S_P_RD;
               ph_in    = !stat.is_run;
            end
         end
         S_R_RD: begin
            cmd.op = mrrs_pkg::OP_R_RD;
            if (stat.rm_end) begin
               state_in = is_run_f ? S_APP : S_SDONE;
            end else begin
               state_in = S_R_CK;
            end
         end
         S_R_CK: begin
            cmd.op   = mrrs_pkg::OP_R_CK;
            state_in = stat.found ? S_H_RD : S_R_RD;
         end
         S_H_RD: begin
            cmd.op = mrrs_pkg::OP_H_RD;
            if (stat.rm_end) begin
               state_in = is_run_f ? S_APP : S_SDONE;
            end else begin
               state_in = S_H_WR;
            end
         end
         S_H_WR: begin
            cmd.op   = mrrs_pkg::OP_H_WR;
            state_in = S_H_RD;
         end
         S_APP: begin
            cmd.op   = mrrs_pkg::OP_APPEND;
            state_in = S_P_RD;
            ph_in    = 1'b1;
         end
         S_SDONE: begin
            cmd.op   = mrrs_pkg::OP_SDONE;
            state_in = S_P_RD;
            ph_in    = 1'b1;
         end
         S_P_RD: begin
            cmd.op   = mrrs_pkg::OP_P_RD;
            state_in = S_P_CK;
         end
         S_P_CK: begin
            cmd.op = mrrs_pkg::OP_P_CK;
            if (!ph_ff) begin
               state_in = (stat.func == mrrs_pkg::FUNC_TICK) ? S_ADV : S_R_RD;
            end else if (stat.func == mrrs_pkg::FUNC_TICK && stat.avail) begin
               state_in = S_L_RD;
            end else begin
               state_in = S_RESP;
            end
         end
         S_ADV: begin
            cmd.op   = mrrs_pkg::OP_ADV;
            state_in = S_P_RD;
            ph_in    = 1'b1;
         end
         S_L_RD: begin
            cmd.op   = mrrs_pkg::OP_L_RD;
            state_in = S_L_CK;
         end
         S_L_CK: begin
            cmd.op   = mrrs_pkg::OP_L_CK;
            state_in = S_RESP;
         end
         S_RESP: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT0;
         ph_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         ph_ff    <= ph_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);

endmodule

// File: sv/mrrs_dpath.sv
`timescale 1ns / 1ps

module mrrs_dpath (
   input  logic               clock,
   input  logic               reset,
   input  mrrs_pkg::cmd_type  cmd,
   input  logic [1:0]         req_func,
   input  logic [5:0]         req_task_id,
   input  logic [2:0]         req_level,
   input  logic               req_keep_level,
   input  logic [7:0]         req_slice,
   output mrrs_pkg::stat_type stat,
   output logic               rsp_status,
   output logic [5:0]         rsp_result_task,
   output logic               rsp_do_switch,
   output logic [7:0]         rsp_timer_reload,
   output logic               rsp_reload_valid
);

   // latched item
   logic [1:0]  f_ff, f_in;
   logic [5:0]  t_ff, t_in;
   logic [2:0]  lvl_ff, lvl_in;
   logic        keep_ff, keep_in;
   logic [7:0]  sl_ff, sl_in;

   // per-item work registers
   logic [mrrs_pkg::CW-1:0]  idx_ff, idx_in;
   logic [mrrs_pkg::CW-1:0]  i_ff, i_in;
   mrrs_pkg::slot_type       slot_ff, slot_in;
   logic [mrrs_pkg::LW-1:0]  tgt_ff, tgt_in;
   logic                     app_ff, app_in;
   logic                     old_v_ff, old_v_in;
   logic [mrrs_pkg::TW-1:0]  old_t_ff, old_t_in;
   logic                     fin_v_ff, fin_v_in;
   logic [mrrs_pkg::TW-1:0]  fin_t_ff, fin_t_in;
   logic                     pv_ff, pv_in;
   logic                     pk_ff, pk_in;
   logic [7:0]               rel_ff, rel_in;
   logic                     afail_ff, afail_in;
   logic [mrrs_pkg::TW-1:0]  aidx_ff, aidx_in;
   logic [mrrs_pkg::TW-1:0]  srda_ff, srda_in;

   // scheduler state
   logic [mrrs_pkg::CW-1:0]  cnt_ff [mrrs_pkg::NUM_LEVELS];
   logic [mrrs_pkg::CW-1:0]  cnt_in [mrrs_pkg::NUM_LEVELS];
   logic [mrrs_pkg::TW-1:0]  cur_ff [mrrs_pkg::NUM_LEVELS];
   logic [mrrs_pkg::TW-1:0]  cur_in [mrrs_pkg::NUM_LEVELS];
   logic [mrrs_pkg::CLW-1:0] cl_ff, cl_in;
   logic                     chg_ff, chg_in;
   logic [mrrs_pkg::NUM_TASKS-1:0] sv_ff, sv_in;

   // memory ports
   logic                          s_we;
   logic [mrrs_pkg::TW-1:0]       s_waddr, s_raddr;
   logic [mrrs_pkg::SLOT_W-1:0]   s_wdata, s_q;
   logic                          l_we;
   logic [mrrs_pkg::LIST_AW-1:0]  l_waddr, l_raddr;
   logic [mrrs_pkg::TW-1:0]       l_wdata, l_q;

   logic [mrrs_pkg::LW-1:0]  la;
   logic [mrrs_pkg::CW-1:0]  cnt_la;
   logic [mrrs_pkg::TW-1:0]  cur_la;
   logic [mrrs_pkg::TW-1:0]  tid;
   logic [mrrs_pkg::CLW-1:0] pick_lv;
   logic [mrrs_pkg::LW-1:0]  tgt_calc;
   logic [mrrs_pkg::CW-1:0]  n_new, cadj, cadv;
   mrrs_pkg::slot_type       slot_rd, slot_wr;
   logic                     cl_ok;

   mrrs_ram #(.WIDTH(mrrs_pkg::SLOT_W), .DEPTH(mrrs_pkg::NUM_TASKS)) u_slot_ram (
      .clock (clock),
      .we    (s_we),
      .waddr (s_waddr),
      .wdata (s_wdata),
      .raddr (s_raddr),
      .rdata (s_q)
   );

   mrrs_ram #(.WIDTH(mrrs_pkg::TW), .DEPTH(mrrs_pkg::LIST_DEPTH)) u_list_ram (
      .clock (clock),
      .we    (l_we),
      .waddr (l_waddr),
      .wdata (l_wdata),
      .raddr (l_raddr),
      .rdata (l_q)
   );

   assign tid     = mrrs_pkg::TW'(t_ff);
   assign slot_rd = sv_ff[srda_ff] ? mrrs_pkg::slot_type'(s_q) : mrrs_pkg::slot_rst(srda_ff);
   assign cl_ok   = int'(cl_ff) < mrrs_pkg::NUM_LEVELS;
   assign s_wdata = slot_wr;

   // lowest-numbered non-empty level
   always_comb begin
      pick_lv = mrrs_pkg::CLW'(mrrs_pkg::NUM_LEVELS);
      for (int k = mrrs_pkg::NUM_LEVELS - 1; k >= 0; k--) begin
         if (cnt_ff[k] != '0) begin
            pick_lv = mrrs_pkg::CLW'(k);
         end
      end
   end

   // level that the current step works on
   always_comb begin
      unique case (cmd.op) inside
         mrrs_pkg::OP_R_RD, mrrs_pkg::OP_R_CK, mrrs_pkg::OP_H_RD, mrrs_pkg::OP_H_WR:
            la = slot_ff.lv;
         mrrs_pkg::OP_APPEND:
            la = tgt_ff;
         default:
            la = cl_ff[mrrs_pkg::LW-1:0];
      endcase
   end

   assign cnt_la = cnt_ff[la];
   assign cur_la = cur_ff[la];

   // target level of a run
   always_comb begin
      if (keep_ff) begin
         tgt_calc = slot_rd.lv;
      end else if (int'(lvl_ff) >= mrrs_pkg::NUM_LEVELS) begin
         tgt_calc = mrrs_pkg::LW'(mrrs_pkg::NUM_LEVELS - 1);
      end else begin
         tgt_calc = mrrs_pkg::LW'(lvl_ff);
      end
   end

   // status to the controller
   always_comb begin
      stat.func      = mrrs_pkg::func_type'(f_ff);
      stat.slot_free = (slot_rd.st == mrrs_pkg::ST_FREE);
      stat.idx_last  = (idx_ff == mrrs_pkg::CW'(mrrs_pkg::NUM_TASKS - 1));
      stat.is_run    = (slot_rd.st == mrrs_pkg::ST_RUN);
      stat.need_rm   = (slot_rd.st == mrrs_pkg::ST_RUN) && (slot_rd.lv != tgt_calc);
      stat.rm_end    = (i_ff >= cnt_la);
      stat.found     = (l_q == tid);
      stat.avail     = pv_ff;
   end

   // step actions
   always_comb begin
      f_in = f_ff; t_in = t_ff; lvl_in = lvl_ff; keep_in = keep_ff; sl_in = sl_ff;
      idx_in = idx_ff; i_in = i_ff; slot_in = slot_ff; tgt_in = tgt_ff; app_in = app_ff;
      old_v_in = old_v_ff; old_t_in = old_t_ff; fin_v_in = fin_v_ff; fin_t_in = fin_t_ff;
      pv_in = pv_ff; pk_in = pk_ff; rel_in = rel_ff; afail_in = afail_ff;
      aidx_in = aidx_ff; srda_in = srda_ff;
      cnt_in = cnt_ff; cur_in = cur_ff; cl_in = cl_ff; chg_in = chg_ff; sv_in = sv_ff;
      s_we = 1'b0; s_waddr = tid; s_raddr = tid; slot_wr = slot_ff;
      l_we = 1'b0; l_waddr = {la, i_ff[mrrs_pkg::TW-1:0]}; l_wdata = l_q;
      l_raddr = {la, i_ff[mrrs_pkg::TW-1:0]};
      n_new = cnt_la - 1'b1;
      cadj  = mrrs_pkg::CW'(cur_la);
      cadv  = mrrs_pkg::CW'(cur_la) + 1'b1;
      unique case (cmd.op)
         mrrs_pkg::OP_LATCH: begin
            f_in = req_func; t_in = req_task_id; lvl_in = req_level;
            keep_in = req_keep_level; sl_in = req_slice;
            idx_in = '0; i_in = '0; pk_in = 1'b0; afail_in = 1'b0;
            old_v_in = 1'b0; fin_v_in = 1'b0; rel_in = 8'd0;
         end
         mrrs_pkg::OP_INIT0: begin
            l_we    = 1'b1;
            l_waddr = '0;
            l_wdata = '0;
         end
         mrrs_pkg::OP_INIT1: begin
            l_we    = 1'b1;
            l_waddr = {mrrs_pkg::LW'(mrrs_pkg::NUM_LEVELS - 1), mrrs_pkg::TW'(0)};
            l_wdata = mrrs_pkg::TW'(1);
         end
         mrrs_pkg::OP_A_RD: begin
            s_raddr = idx_ff[mrrs_pkg::TW-1:0];
            srda_in = idx_ff[mrrs_pkg::TW-1:0];
         end
         mrrs_pkg::OP_A_CK: begin
            // first free slot becomes allocated
            if (slot_rd.st == mrrs_pkg::ST_FREE) begin
               s_we       = 1'b1;
               s_waddr    = srda_ff;
               slot_wr    = slot_rd;
               slot_wr.st = mrrs_pkg::ST_ALLOC;
               sv_in[srda_ff] = 1'b1;
               aidx_in    = srda_ff;
            end else begin
               idx_in = idx_ff + 1'b1;
               if (idx_ff == mrrs_pkg::CW'(mrrs_pkg::NUM_TASKS - 1)) begin
                  afail_in = 1'b1;
               end
            end
         end
         mrrs_pkg::OP_T_RD: begin
            s_raddr = tid;
            srda_in = tid;
         end
         mrrs_pkg::OP_T_CK: begin
            slot_in = slot_rd;
            tgt_in  = tgt_calc;
            app_in  = !((slot_rd.st == mrrs_pkg::ST_RUN) && (slot_rd.lv == tgt_calc));
            i_in    = '0;
         end
         mrrs_pkg::OP_R_RD: begin
            l_raddr = {la, i_ff[mrrs_pkg::TW-1:0]};
         end
         mrrs_pkg::OP_R_CK: begin
            // found: shrink the list and fix its cursor
            if (l_q == tid) begin
               cnt_in[la] = n_new;
               if (i_ff < cadj) begin
                  cadj = cadj - 1'b1;
               end
               if (cadj >= n_new) begin
                  cadj = '0;
               end
               cur_in[la] = cadj[mrrs_pkg::TW-1:0];
            end else begin
               i_in = i_ff + 1'b1;
            end
         end
         mrrs_pkg::OP_H_RD: begin
            cadv    = i_ff + 1'b1;
            l_raddr = {la, cadv[mrrs_pkg::TW-1:0]};
         end
         mrrs_pkg::OP_H_WR: begin
            l_we    = 1'b1;
            l_waddr = {la, i_ff[mrrs_pkg::TW-1:0]};
            l_wdata = l_q;
            i_in    = i_ff + 1'b1;
         end
         mrrs_pkg::OP_APPEND: begin
            s_we       = 1'b1;
            s_waddr    = tid;
            slot_wr.st = mrrs_pkg::ST_RUN;
            slot_wr.lv = tgt_ff;
            slot_wr.sl = (sl_ff != 8'd0) ? sl_ff : slot_ff.sl;
            sv_in[tid] = 1'b1;
            if (app_ff && (cnt_la < mrrs_pkg::CW'(mrrs_pkg::NUM_TASKS))) begin
               l_we       = 1'b1;
               l_waddr    = {tgt_ff, cnt_la[mrrs_pkg::TW-1:0]};
               l_wdata    = tid;
               cnt_in[la] = cnt_la + 1'b1;
            end
            chg_in = 1'b1;
         end
         mrrs_pkg::OP_SDONE: begin
            s_we       = 1'b1;
            s_waddr    = tid;
            slot_wr.st = mrrs_pkg::ST_ALLOC;
            sv_in[tid] = 1'b1;
            // sleeping the running task reselects at once
            if (old_v_ff && (old_t_ff == tid)) begin
               cl_in  = pick_lv;
               chg_in = 1'b0;
               pk_in  = 1'b1;
            end
         end
         mrrs_pkg::OP_P_RD: begin
            pv_in   = cl_ok && (cnt_la != '0) && (mrrs_pkg::CW'(cur_la) < cnt_la);
            l_raddr = {la, cur_la};
         end
         mrrs_pkg::OP_P_CK: begin
            if (cmd.ph) begin
               fin_v_in = pv_ff;
               fin_t_in = l_q;
            end else begin
               old_v_in = pv_ff;
               old_t_in = l_q;
            end
         end
         mrrs_pkg::OP_ADV: begin
            // round robin step, then pending level change
            if (cl_ok) begin
               if (cadv >= cnt_la) begin
                  cadv = '0;
               end
               cur_in[la] = cadv[mrrs_pkg::TW-1:0];
            end
            if (chg_ff) begin
               cl_in  = pick_lv;
               chg_in = 1'b0;
            end
         end
         mrrs_pkg::OP_L_RD: begin
            s_raddr = fin_t_ff;
            srda_in = fin_t_ff;
         end
         mrrs_pkg::OP_L_CK: begin
            rel_in = slot_rd.sl;
         end
         default: begin
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < mrrs_pkg::NUM_LEVELS; k++) begin
            cnt_ff[k] <= (k == 0 || k == mrrs_pkg::NUM_LEVELS - 1) ?
                         mrrs_pkg::CW'(1) : '0;
            cur_ff[k] <= '0;
         end
         cl_ff  <= '0;
         chg_ff <= 1'b1;
         sv_ff  <= '0;
      end else begin
         cnt_ff <= cnt_in;
         cur_ff <= cur_in;
         cl_ff  <= cl_in;
         chg_ff <= chg_in;
         sv_ff  <= sv_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      f_ff <= f_in; t_ff <= t_in; lvl_ff <= lvl_in; keep_ff <= keep_in; sl_ff <= sl_in;
      idx_ff <= idx_in; i_ff <= i_in; slot_ff <= slot_in; tgt_ff <= tgt_in;
      app_ff <= app_in; old_v_ff <= old_v_in; old_t_ff <= old_t_in;
      fin_v_ff <= fin_v_in; fin_t_ff <= fin_t_in; pv_ff <= pv_in; pk_ff <= pk_in;
      rel_ff <= rel_in; afail_ff <= afail_in; aidx_ff <= aidx_in; srda_ff <= srda_in;
   end

   // result fields
   always_comb begin
      rsp_status       = 1'b0;
      rsp_result_task  = fin_v_ff ? 6'(fin_t_ff) : 6'd0;
      rsp_do_switch    = 1'b0;
      rsp_timer_reload = 8'd0;
      rsp_reload_valid = 1'b0;
      case (mrrs_pkg::func_type'(f_ff))
         mrrs_pkg::FUNC_ALLOC: begin
            rsp_status      = afail_ff;
            rsp_result_task = afail_ff ? 6'd0 : 6'(aidx_ff);
         end
         mrrs_pkg::FUNC_SLEEP: begin
            rsp_do_switch = pk_ff && fin_v_ff;
         end
         mrrs_pkg::FUNC_TICK: begin
            rsp_do_switch    = fin_v_ff && (!old_v_ff || (fin_t_ff != old_t_ff));
            rsp_timer_reload = fin_v_ff ? rel_ff : 8'd0;
            rsp_reload_valid = fin_v_ff;
         end
         default: begin
         end
      endcase
   end

endmodule

// File: sv/multilevel_round_robin_scheduler.sv
`timescale 1ns / 1ps
// Allocate walks the slot memory from slot 0, reading and checking each slot in
// turn until it finds the first free slot or reaches the last one.
// Run and sleep, when they take a task out of its level list, search it there and
// shift the later entries down in the level list memory. A tick advances the cursor.
// One item at a time; each result is strobed for one cycle and cannot be stalled.
// After synchronous reset the block is busy while it seeds the level lists.

module multilevel_round_robin_scheduler (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_func,
   input  logic [5:0]  req_task_id,
   input  logic [2:0]  req_level,
   input  logic        req_keep_level,
   input  logic [7:0]  req_slice,
   output logic        rsp_valid,
   output logic        rsp_status,
   output logic [5:0]  rsp_result_task,
   output logic        rsp_do_switch,
   output logic [7:0]  rsp_timer_reload,
   output logic        rsp_reload_valid
);

   mrrs_pkg::cmd_type  cmd;
   mrrs_pkg::stat_type stat;

   mrrs_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_func    (req_func),
      .req_task_id (req_task_id),
      .stat        (stat),
      .cmd         (cmd),
      .busy        (busy),
      .rsp_valid   (rsp_valid)
   );

   mrrs_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_func         (req_func),
      .req_task_id      (req_task_id),
      .req_level        (req_level),
      .req_keep_level   (req_keep_level),
      .req_slice        (req_slice),
      .stat             (stat),
      .rsp_status       (rsp_status),
      .rsp_result_task  (rsp_result_task),
      .rsp_do_switch    (rsp_do_switch),
      .rsp_timer_reload (rsp_timer_reload),
      .rsp_reload_valid (rsp_reload_valid)
   );

   // result strobe lasts one cycle
   a_rsp_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held");

   // an accepted item keeps the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("item accepted without going busy");

   // only a tick loads the timer
   a_reload_tick: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_reload_valid) |-> (stat.func == mrrs_pkg::FUNC_TICK))
      else $error("reload on a non-tick item");

   // results come only with the latch step gone
   a_no_latch_resp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (cmd.op == mrrs_pkg::OP_NONE))
      else $error("datapath step during result cycle");

endmodule

// File: bench/sched_checker.sv
`timescale 1ns / 1ps

module sched_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [1:0]  req_func,
   input  logic [5:0]  req_task_id,
   input  logic [2:0]  req_level,
   input  logic        req_keep_level,
   input  logic [7:0]  req_slice,
   input  logic        rsp_valid,
   input  logic        rsp_status,
   input  logic [5:0]  rsp_result_task,
   input  logic        rsp_do_switch,
   input  logic [7:0]  rsp_timer_reload,
   input  logic        rsp_reload_valid,
   output int          errors,
   output int          pending
);

   typedef struct packed {
      logic       status;
      logic [5:0] task_id;
      logic       do_switch;
      logic [7:0] reload;
      logic       reload_valid;
   } sched_result_type;

   // scheduler shadow state
   mrrs_pkg::sstate_type task_st [mrrs_pkg::NUM_TASKS];
   logic [2:0] task_lv  [mrrs_pkg::NUM_TASKS];
   logic [7:0] task_sl  [mrrs_pkg::NUM_TASKS];
   logic [5:0] lv_list  [mrrs_pkg::NUM_LEVELS][mrrs_pkg::NUM_TASKS];
   int         lv_cnt   [mrrs_pkg::NUM_LEVELS];
   int         lv_cur   [mrrs_pkg::NUM_LEVELS];
   int         act_level;
   bit         lv_dirty;

   sched_result_type sched_q[$];

   assign pending = sched_q.size();

   function automatic void sched_init();
      for (int i = 0; i < mrrs_pkg::NUM_TASKS; i++) begin
         task_st[i] = mrrs_pkg::ST_FREE;
         task_lv[i] = '0;
         task_sl[i] = '0;
      end
      for (int l = 0; l < mrrs_pkg::NUM_LEVELS; l++) begin
         lv_cnt[l] = 0;
         lv_cur[l] = 0;
         for (int i = 0; i < mrrs_pkg::NUM_TASKS; i++) lv_list[l][i] = '0;
      end
      task_st[0] = mrrs_pkg::ST_RUN; task_sl[0] = 8'd2;
      task_st[1] = mrrs_pkg::ST_RUN; task_lv[1] = 3'(mrrs_pkg::NUM_LEVELS - 1);
      task_sl[1] = 8'd1;
      lv_list[0][0] = 6'd0; lv_cnt[0] = 1;
      lv_list[mrrs_pkg::NUM_LEVELS-1][0] = 6'd1; lv_cnt[mrrs_pkg::NUM_LEVELS-1] = 1;
      act_level = 0;
      lv_dirty = 1'b1;
   endfunction

   // task under the cursor of the active level, -1 for none
   function automatic int active_task();
      if (act_level >= mrrs_pkg::NUM_LEVELS) return -1;
      if (lv_cnt[act_level] == 0) return -1;
      if (lv_cur[act_level] >= lv_cnt[act_level]) return -1;
      return int'(lv_list[act_level][lv_cur[act_level]]);
   endfunction

   function automatic void choose_level();
      int l;
      for (l = 0; l < mrrs_pkg::NUM_LEVELS; l++)
         if (lv_cnt[l] > 0) break;
      act_level = l;
      lv_dirty = 1'b0;
   endfunction

   function automatic void enqueue_task(int t);
      int l;
      l = task_lv[t];
      if (lv_cnt[l] < mrrs_pkg::NUM_TASKS) begin
         lv_list[l][lv_cnt[l]] = 6'(t);
         lv_cnt[l]++;
      end
      task_st[t] = mrrs_pkg::ST_RUN;
   endfunction

   function automatic void dequeue_task(int t);
      int l, i, n;
      l = task_lv[t];
      task_st[t] = mrrs_pkg::ST_ALLOC;
      n = lv_cnt[l];
      for (i = 0; i < n; i++)
         if (lv_list[l][i] == 6'(t)) break;
      if (i >= n) return;
      n--;
      lv_cnt[l] = n;
      if (i < lv_cur[l]) lv_cur[l]--;
      if (lv_cur[l] >= n) lv_cur[l] = 0;
      for (; i < n; i++) lv_list[l][i] = lv_list[l][i+1];
   endfunction

   function automatic sched_result_type sched_predict(mrrs_pkg::func_type f, int t,
                                                      int lvl, bit keep, logic [7:0] sl);
      sched_result_type r;
      int cur, old, target, c, now;
      r = '0;
      case (f)
         mrrs_pkg::FUNC_ALLOC: begin
            int i;
            for (i = 0; i < mrrs_pkg::NUM_TASKS; i++)
               if (task_st[i] == mrrs_pkg::ST_FREE) break;
            if (i < mrrs_pkg::NUM_TASKS) begin
               task_st[i] = mrrs_pkg::ST_ALLOC;
               r.task_id = 6'(i);
            end else r.status = 1'b1;
         end
         mrrs_pkg::FUNC_RUN: begin
            target = keep ? int'(task_lv[t]) : lvl;
            if (target >= mrrs_pkg::NUM_LEVELS) target = mrrs_pkg::NUM_LEVELS - 1;
            if (sl != 0) task_sl[t] = sl;
            if (task_st[t] == mrrs_pkg::ST_RUN && int'(task_lv[t]) != target)
               dequeue_task(t);
            if (task_st[t] != mrrs_pkg::ST_RUN) begin
               task_lv[t] = 3'(target);
               enqueue_task(t);
            end
            lv_dirty = 1'b1;
            cur = active_task();
            r.task_id = cur < 0 ? 6'd0 : 6'(cur);
         end
         mrrs_pkg::FUNC_SLEEP: begin
            if (task_st[t] == mrrs_pkg::ST_RUN) begin
               now = active_task();
               dequeue_task(t);
               if (now == t) begin
                  choose_level();
                  if (active_task() >= 0) r.do_switch = 1'b1;
               end
            end
            cur = active_task();
            r.task_id = cur < 0 ? 6'd0 : 6'(cur);
         end
         default: begin
            old = active_task();
            if (act_level < mrrs_pkg::NUM_LEVELS) begin
               c = lv_cur[act_level] + 1;
               if (c >= lv_cnt[act_level]) c = 0;
               lv_cur[act_level] = c;
            end
            if (lv_dirty) choose_level();
            cur = active_task();
            if (cur >= 0) begin
               r.task_id      = 6'(cur);
               r.reload       = task_sl[cur];
               r.reload_valid = 1'b1;
               r.do_switch    = (cur != old);
            end
         end
      endcase
      return r;
   endfunction

   // result check first, then prediction of the newly accepted item
   always @(posedge clock) begin
      sched_result_type want, got;
      if (reset) begin
         sched_init();
         sched_q.delete();
         errors <= 0;
      end else begin
         if (rsp_valid) begin
            got = '{rsp_status, rsp_result_task, rsp_do_switch, rsp_timer_reload,
                    rsp_reload_valid};
            if (sched_q.size() == 0) begin
               $display("%0t: unexpected result %p", $time, got);
               errors <= errors + 1;
            end else begin
               want = sched_q.pop_front();
               if (got !== want) begin
                  $display("%0t: result mismatch expected %p actual %p", $time, want, got);
                  errors <= errors + 1;
               end
            end
         end
         if (start && !busy)
            sched_q.push_back(sched_predict(mrrs_pkg::func_type'(req_func),
                                            int'(req_task_id), int'(req_level),
                                            req_keep_level, req_slice));
      end
   end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

   localparam int N_RANDOM = 1630;
   localparam int IDLE_LIMIT = 5000;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic [1:0] req_func = '0;
   logic [5:0] req_task_id = '0;
   logic [2:0] req_level = '0;
   logic       req_keep_level = 1'b0;
   logic [7:0] req_slice = '0;
   logic       busy, rsp_valid, rsp_status, rsp_do_switch, rsp_reload_valid;
   logic [5:0] rsp_result_task;
   logic [7:0] rsp_timer_reload;
   int         errors, pending;
   int         idle_cycles = 0;
   int         func_seen [4] = '{0, 0, 0, 0};
   bit         no_gaps = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   multilevel_round_robin_scheduler u_dut (.*);

   sched_checker u_checker (.*);

   // watchdog on cycles with no handshake on either side
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: watchdog expired, %0d results outstanding", $time, pending);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // present one item and hold it until accepted
   task automatic issue(mrrs_pkg::func_type f, int t, int l, bit k, int s);
      start          <= 1'b1;
      req_func       <= f;
      req_task_id    <= 6'(t);
      req_level      <= 3'(l);
      req_keep_level <= k;
      req_slice      <= 8'(s);
      @(posedge clock);
      while (busy) @(posedge clock);
      func_seen[f]++;
   endtask

   task automatic idle_gap();
      int r, n;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 55) return;
      n = (r < 92) ? $urandom_range(1, 3) : $urandom_range(20, 120);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   initial begin
      int r, t;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: empty list paths, level moves, current-task sleep, slice extremes
      issue(mrrs_pkg::FUNC_TICK, 0, 0, 0, 0);
      issue(mrrs_pkg::FUNC_TICK, 0, 0, 0, 0);
      issue(mrrs_pkg::FUNC_ALLOC, 0, 0, 0, 0);
      issue(mrrs_pkg::FUNC_RUN, 2, 3, 0, 255);
      issue(mrrs_pkg::FUNC_RUN, 2, 6, 1, 0);
      issue(mrrs_pkg::FUNC_RUN, 5, 7, 0, 1);
      issue(mrrs_pkg::FUNC_SLEEP, 0, 0, 0, 0);
      issue(mrrs_pkg::FUNC_TICK, 0, 0, 0, 0);
      issue(mrrs_pkg::FUNC_SLEEP, 9, 0, 0, 0);
      issue(mrrs_pkg::FUNC_RUN, 63, 0, 0, 128);
      issue(mrrs_pkg::FUNC_TICK, 0, 0, 0, 0);
      issue(mrrs_pkg::FUNC_SLEEP, 63, 0, 0, 0);
      issue(mrrs_pkg::FUNC_SLEEP, 1, 0, 0, 0);
      issue(mrrs_pkg::FUNC_SLEEP, 2, 0, 0, 0);
      issue(mrrs_pkg::FUNC_SLEEP, 5, 0, 0, 0);
      issue(mrrs_pkg::FUNC_TICK, 0, 7, 1, 255);
      issue(mrrs_pkg::FUNC_RUN, 2, 0, 0, 0);
      issue(mrrs_pkg::FUNC_RUN, 2, 0, 0, 77);
      issue(mrrs_pkg::FUNC_TICK, 0, 0, 0, 0);
      issue(mrrs_pkg::FUNC_RUN, 1, 0, 0, 9);
      issue(mrrs_pkg::FUNC_RUN, 1, 0, 0, 0);
      issue(mrrs_pkg::FUNC_TICK, 0, 0, 0, 0);
      issue(mrrs_pkg::FUNC_ALLOC, 63, 7, 1, 255);

      // random mix, weighted toward a small set of slots so lists stay busy
      for (int i = 0; i < N_RANDOM; i++) begin
         no_gaps = ((i / 150) % 3) == 1;
         idle_gap();
         r = $urandom_range(0, 99);
         t = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 15) : $urandom_range(0, 63);
         if (r < 12)
            issue(mrrs_pkg::FUNC_ALLOC, $urandom_range(0, 63), $urandom_range(0, 7),
                  $urandom_range(0, 1), $urandom_range(0, 255));
         else if (r < 45)
            issue(mrrs_pkg::FUNC_RUN, t, $urandom_range(0, 7), $urandom_range(0, 3) == 0,
                  ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 255));
         else if (r < 65)
            issue(mrrs_pkg::FUNC_SLEEP, t, $urandom_range(0, 7), $urandom_range(0, 1),
                  $urandom_range(0, 255));
         else
            issue(mrrs_pkg::FUNC_TICK, t, $urandom_range(0, 7), $urandom_range(0, 1),
                  $urandom_range(0, 255));
      end
      start <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (300) @(posedge clock);

      $display("items: %0d allocate, %0d run, %0d sleep, %0d tick",
               func_seen[0], func_seen[1], func_seen[2], func_seen[3]);
      $display("random part mixed gapped and back-to-back stretches");
      if (errors == 0 && pending == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// File: multilevel_round_robin_scheduler.f
sv/mrrs_pkg.sv
sv/mrrs_ram.sv
sv/mrrs_ctrl.sv
sv/mrrs_dpath.sv
sv/multilevel_round_robin_scheduler.sv
bench/sched_checker.sv
bench/testbench.sv
